// ===== hdl/sts_pkg.sv =====
// shared constants, types and codes for the triplet scatter-accumulate block
`timescale 1ns / 1ps
package sts_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 6;
    localparam int ADDEND_W = 32;
    localparam int VAL_W    = 40;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLUMNS = 64;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    // command codes, code three behaves as a plain read
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CLR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ROW_OOR = 2'd1;
    localparam logic [STAT_W-1:0] STAT_COL_OOR = 2'd2;

    // register index taken from the word address bit
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] column_count;
    } t_cfg;

endpackage

// ===== hdl/sts_if.sv =====
// command and response channel interfaces
`timescale 1ns / 1ps
interface sts_cmd_if;
    import sts_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           column_index;
    logic signed [ADDEND_W-1:0] addend;

    modport source (output valid, cmd, row_index, column_index, addend, input ready);
    modport sink   (input valid, cmd, row_index, column_index, addend, output ready);
endinterface

interface sts_rsp_if;
    import sts_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] entry_value;
    logic [STAT_W-1:0]       status;

    modport source (output valid, entry_value, status, input ready);
    modport sink   (input valid, entry_value, status, output ready);
endinterface

// ===== hdl/sts_cfg_regs.sv =====
// apb register file holding the row and column counts
`timescale 1ns / 1ps
module sts_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sts_pkg::APB_AW-1:0]  paddr,
    input  logic [sts_pkg::APB_DW-1:0]  pwdata,
    output logic [sts_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output sts_pkg::t_cfg               o_cfg
);
    import sts_pkg::*;

    logic [CNT_W-1:0] r_row_count;
    logic [CNT_W-1:0] r_column_count;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= CNT_RESET;
            r_column_count <= CNT_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_ROW_COUNT:    r_row_count    <= pwdata[CNT_W-1:0];
                REG_COLUMN_COUNT: r_column_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_DW'(r_row_count);
            REG_COLUMN_COUNT: prdata = APB_DW'(r_column_count);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.row_count    = r_row_count;
    assign o_cfg.column_count = r_column_count;

endmodule

// ===== hdl/sts_ram.sv =====
// single write port, single registered read port store
`timescale 1ns / 1ps
module sts_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sts_rmw.sv =====
// read-modify-write pipeline with forwarding, clear sweep and output register
`timescale 1ns / 1ps
module sts_rmw #(
    parameter int MAX_ROWS    = sts_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = sts_pkg::DEF_MAX_COLUMNS,
    parameter int DEPTH       = MAX_ROWS * MAX_COLUMNS,
    parameter int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sts_pkg::t_cfg              i_cfg,
    sts_cmd_if.sink                    i_cmd,
    sts_rsp_if.source                  o_rsp,
    output logic                       o_ram_we,
    output logic [ADDR_W-1:0]          o_ram_waddr,
    output logic [sts_pkg::VAL_W-1:0]  o_ram_wdata,
    output logic                       o_ram_re,
    output logic [ADDR_W-1:0]          o_ram_raddr,
    input  logic [sts_pkg::VAL_W-1:0]  i_ram_rdata
);
    import sts_pkg::*;

    localparam int LIN_W = IDX_W + CNT_W + 1;
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // clear sweep
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // stage one: entry being read
    logic                r_s1_valid;
    logic [CMD_W-1:0]    r_s1_cmd;
    logic [STAT_W-1:0]   r_s1_stat;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic [ADDEND_W-1:0] r_s1_addend;

    // last write, forwarded to a read issued at the same edge
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [VAL_W-1:0]  r_fwd_data;

    // output register
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic [STAT_W-1:0] r_out_stat;

    logic [CNT_W-1:0]  w_nr;
    logic [CNT_W-1:0]  w_nc;
    logic              w_in_acc;
    logic              w_s1_adv;
    logic [STAT_W-1:0] w_in_stat;
    logic [LIN_W-1:0]  w_lin;
    logic [VAL_W-1:0]  w_old;
    logic [VAL_W:0]    w_sum;
    logic [VAL_W-1:0]  w_sat;
    logic              w_s1_wr;
    logic [VAL_W-1:0]  n_out_value;
    logic [VAL_W-1:0]  n_wr_data;

    assign w_nr = (32'(i_cfg.row_count) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : i_cfg.row_count;
    assign w_nc = (32'(i_cfg.column_count) > MAX_COLUMNS) ?
                  CNT_W'(MAX_COLUMNS) : i_cfg.column_count;

    assign w_s1_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_clearing && (!r_s1_valid || w_s1_adv);
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;

    // row check wins over column check
    always_comb begin
        if ({1'b0, i_cmd.row_index} >= w_nr) begin
            w_in_stat = STAT_ROW_OOR;
        end else if ({1'b0, i_cmd.column_index} >= w_nc) begin
            w_in_stat = STAT_COL_OOR;
        end else begin
            w_in_stat = STAT_OK;
        end
    end

    // column-major linear address
    assign w_lin = LIN_W'(i_cmd.row_index) + LIN_W'(i_cmd.column_index) * LIN_W'(w_nr);

    assign o_ram_re    = w_in_acc;
    assign o_ram_raddr = ADDR_W'(w_lin);

    assign w_old = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : i_ram_rdata;
    assign w_sum = {w_old[VAL_W-1], w_old} +
                   {{(VAL_W+1-ADDEND_W){r_s1_addend[ADDEND_W-1]}}, r_s1_addend};

    always_comb begin
        if (w_sum[VAL_W] != w_sum[VAL_W-1]) begin
            w_sat = w_sum[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            w_sat = w_sum[VAL_W-1:0];
        end
    end

    always_comb begin
        w_s1_wr     = 1'b0;
        n_wr_data   = '0;
        n_out_value = w_old;
        if (r_s1_stat != STAT_OK) begin
            n_out_value = '0;
        end else begin
            case (r_s1_cmd)
                CMD_ADD: begin
                    w_s1_wr     = w_s1_adv;
                    n_wr_data   = w_sat;
                    n_out_value = w_sat;
                end
                CMD_READ_CLR: begin
                    w_s1_wr   = w_s1_adv;
                    n_wr_data = '0;
                end
                CMD_READ: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_clearing) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_clr_addr;
            o_ram_wdata = '0;
        end else begin
            o_ram_we    = w_s1_wr;
            o_ram_waddr = r_s1_addr;
            o_ram_wdata = n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_wr) begin
                r_fwd_valid <= 1'b1;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cmd    <= i_cmd.cmd;
            r_s1_stat   <= w_in_stat;
            r_s1_addr   <= ADDR_W'(w_lin);
            r_s1_addend <= i_cmd.addend;
        end
        if (w_s1_wr) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_wr_data;
        end
        if (w_s1_adv) begin
            r_out_value <= n_out_value;
            r_out_stat  <= r_s1_stat;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.entry_value = r_out_value;
    assign o_rsp.status      = r_out_stat;

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s1_valid && !r_out_valid))
        else $error("item in flight during clear sweep");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_stat != STAT_OK)) |-> (r_out_value == '0))
        else $error("flagged result carries a nonzero value");

    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_clearing || w_s1_adv))
        else $error("store written without a retiring item");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> $stable(i_ram_rdata))
        else $error("read data lost while stage one is stalled");

endmodule

// ===== hdl/sparse_triplet_scatter_accumulate.sv =====
// top level of the triplet scatter-accumulate block
//
//  channel   dir   handshake            payload
//  i_cmd     in    valid / ready        cmd, row_index, column_index, addend
//  o_rsp     out   valid / ready        entry_value, status
//  apb       in    psel, penable        row_count at 0x0, column_count at 0x4
//
// one transaction per cycle sustained while o_rsp is ready; from acceptance each goes
// through the store read, then add, saturate and write back into the response register
// a write followed at once by a read of the same entry is served by forwarding
// after reset a clear sweep zeroes all MAX_ROWS * MAX_COLUMNS entries of the store
// (4096 by default), with i_cmd.ready low; register writes are taken throughout
// a stalled response holds stage one and so drops i_cmd.ready
`timescale 1ns / 1ps
module sparse_triplet_scatter_accumulate #(
    parameter int MAX_ROWS    = sts_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = sts_pkg::DEF_MAX_COLUMNS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sts_cmd_if.sink                     i_cmd,
    sts_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sts_pkg::APB_AW-1:0]  paddr,
    input  logic [sts_pkg::APB_DW-1:0]  pwdata,
    output logic [sts_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import sts_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg              w_cfg;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [VAL_W-1:0]  w_ram_wdata;
    logic              w_ram_re;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [VAL_W-1:0]  w_ram_rdata;

    sts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sts_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    sts_rmw #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_rmw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

endmodule

// ===== tb/sts_checker.sv =====
// scoreboard for the triplet scatter-accumulate block: store model, response and register checks
`timescale 1ns / 1ps
module sts_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sts_cmd_if                         i_cmd,
    sts_rsp_if                         i_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [sts_pkg::APB_AW-1:0] paddr,
    input  logic [sts_pkg::APB_DW-1:0] pwdata,
    input  logic [sts_pkg::APB_DW-1:0] prdata,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_transactions,
    output int                         o_flagged,
    output int                         o_saturated
);
    import sts_pkg::*;

    localparam int     STORE_DEPTH = DEF_MAX_ROWS * DEF_MAX_COLUMNS;
    localparam longint SUM_HI      = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam longint SUM_LO      = -(longint'(1) <<< (VAL_W - 1));

    typedef struct {
        logic signed [VAL_W-1:0] entry_value;
        logic [STAT_W-1:0]       status;
    } t_entry_rsp;

    t_entry_rsp              rsp_fifo[$];
    logic signed [VAL_W-1:0] entries[STORE_DEPTH];
    logic [CNT_W-1:0]        rows_reg;
    logic [CNT_W-1:0]        cols_reg;

    function automatic int clip_count(input logic [CNT_W-1:0] n, input int ceiling);
        return (int'(n) < ceiling) ? int'(n) : ceiling;
    endfunction

    // updates the store model and returns the response the command should produce
    function automatic t_entry_rsp scatter_update(input logic [CMD_W-1:0] op,
                                                  input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c,
                                                  input logic signed [ADDEND_W-1:0] a);
        int         nr;
        int         nc;
        int         slot;
        longint     sum;
        t_entry_rsp res;
        nr = clip_count(rows_reg, DEF_MAX_ROWS);
        nc = clip_count(cols_reg, DEF_MAX_COLUMNS);
        res.entry_value = '0;
        res.status      = STAT_OK;
        if (int'(r) >= nr) begin
            res.status = STAT_ROW_OOR;
            o_flagged++;
        end else if (int'(c) >= nc) begin
            res.status = STAT_COL_OOR;
            o_flagged++;
        end else begin
            slot = int'(r) + int'(c) * nr;
            if (op == CMD_ADD) begin
                sum = longint'(entries[slot]) + longint'(a);
                if (sum > SUM_HI) begin
                    sum = SUM_HI;
                    o_saturated++;
                end else if (sum < SUM_LO) begin
                    sum = SUM_LO;
                    o_saturated++;
                end
                entries[slot]   = sum[VAL_W-1:0];
                res.entry_value = entries[slot];
            end else begin
                res.entry_value = entries[slot];
                if (op == CMD_READ_CLR) begin
                    entries[slot] = '0;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $realtime, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_entry_rsp        want;
        logic [APB_DW-1:0] reg_value;
        if (!i_rst_n) begin
            foreach (entries[k]) entries[k] = '0;
            rows_reg = CNT_RESET;
            cols_reg = CNT_RESET;
            rsp_fifo.delete();
        end else begin
            if (psel && penable && pready) begin
                reg_value = (paddr[2] == REG_COLUMN_COUNT) ? APB_DW'(cols_reg)
                                                           : APB_DW'(rows_reg);
                if (pwrite) begin
                    if (paddr[2] == REG_ROW_COUNT) begin
                        rows_reg = pwdata[CNT_W-1:0];
                    end else begin
                        cols_reg = pwdata[CNT_W-1:0];
                    end
                end else if (prdata !== reg_value) begin
                    report_mismatch($sformatf("register read at 0x%0h gave 0x%0h, want 0x%0h",
                                              paddr, prdata, reg_value));
                end
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_fifo.size() == 0) begin
                    report_mismatch("response transaction with no command outstanding");
                end else begin
                    want = rsp_fifo.pop_front();
                    if (i_rsp.entry_value !== want.entry_value) begin
                        report_mismatch($sformatf("entry_value %0d, want %0d",
                                                  i_rsp.entry_value, want.entry_value));
                    end
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  i_rsp.status, want.status));
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                rsp_fifo.push_back(scatter_update(i_cmd.cmd, i_cmd.row_index,
                                                  i_cmd.column_index, i_cmd.addend));
                o_transactions++;
            end
        end
        o_pending = rsp_fifo.size();
    end

endmodule

// ===== tb/sparse_triplet_scatter_accumulate_tb.sv =====
// testbench top for the triplet scatter-accumulate block: stimulus, flow control and verdict
`timescale 1ns / 1ps
module sparse_triplet_scatter_accumulate_tb;
    import sts_pkg::*;

    // code three is not in the package, it behaves as a plain read
    localparam logic [CMD_W-1:0]    CMD_ALT_READ  = 2'd3;
    localparam logic [ADDEND_W-1:0] ADDEND_MAX    = 32'h7FFF_FFFF;
    localparam logic [ADDEND_W-1:0] ADDEND_MIN    = 32'h8000_0000;
    localparam logic [ADDEND_W-1:0] ADDEND_ONE    = 32'h0001_0000;
    localparam int                  LONG_HOLD     = 64;
    localparam int                  SETTLE_CYCLES = 8;
    localparam int                  SAT_RUN       = 270;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sts_cmd_if cmd_ch ();
    sts_rsp_if rsp_ch ();

    int errors;
    int pending;
    int transactions;
    int flagged;
    int saturated;
    bit gaps_on       = 1'b1;
    int hold_requests = 0;
    int rows_now;
    int cols_now;

    sparse_triplet_scatter_accumulate DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sts_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_ch),
        .i_rsp          (rsp_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_transactions (transactions),
        .o_flagged      (flagged),
        .o_saturated    (saturated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("sparse_triplet_scatter_accumulate_tb: FAIL");
        $finish;
    end

    // response side: random stall bursts, plus a long hold-off on request
    initial begin : receiver
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready = 1'b0;
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic push_item(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [ADDEND_W-1:0] a);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid        = 1'b1;
        cmd_ch.cmd          = op;
        cmd_ch.row_index    = r;
        cmd_ch.column_index = c;
        cmd_ch.addend       = a;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drain, let the pipeline settle, then write and read back both counts
    task automatic reconfigure(input int rows, input int cols);
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_access(1'b1, REG_ROW_COUNT, APB_DW'(rows));
        apb_access(1'b1, REG_COLUMN_COUNT, APB_DW'(cols));
        apb_access(1'b0, REG_ROW_COUNT, '0);
        apb_access(1'b0, REG_COLUMN_COUNT, '0);
        rows_now = rows;
        cols_now = cols;
    endtask

    task automatic push_random_item();
        int                  pick;
        int                  rlim;
        int                  clim;
        logic [CMD_W-1:0]    op;
        logic [IDX_W-1:0]    r;
        logic [IDX_W-1:0]    c;
        logic [ADDEND_W-1:0] a;
        rlim = (rows_now > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_now;
        clim = (cols_now > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols_now;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            op = CMD_ADD;
        end else if (pick < 7) begin
            op = CMD_READ;
        end else if (pick < 9) begin
            op = CMD_READ_CLR;
        end else begin
            op = CMD_ALT_READ;
        end
        pick = $urandom_range(0, 19);
        if (pick < 3 || rlim == 0 || clim == 0) begin
            r = IDX_W'($urandom_range(0, 63));
            c = IDX_W'($urandom_range(0, 63));
        end else if (pick < 10) begin
            // a few hot entries so sums build up and forwarding gets exercised
            r = IDX_W'($urandom_range(0, ((rlim < 2) ? rlim : 2) - 1));
            c = IDX_W'($urandom_range(0, ((clim < 2) ? clim : 2) - 1));
        end else begin
            r = IDX_W'($urandom_range(0, rlim - 1));
            c = IDX_W'($urandom_range(0, clim - 1));
        end
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            a = ADDEND_MAX;
        end else if (pick < 4) begin
            a = ADDEND_MIN;
        end else if (pick < 5) begin
            a = '0;
        end else if (pick < 6) begin
            a = '1;
        end else if (pick < 13) begin
            a = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
        end else begin
            a = $urandom;
        end
        push_item(op, r, c, a);
    endtask

    initial begin : stimulus
        cmd_ch.valid        = 1'b0;
        cmd_ch.cmd          = CMD_ADD;
        cmd_ch.row_index    = '0;
        cmd_ch.column_index = '0;
        cmd_ch.addend       = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        rows_now            = int'(CNT_RESET);
        cols_now            = int'(CNT_RESET);
        i_rst_n             = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset counts: corner entries, back-to-back adds, clear and alias read
        push_item(CMD_ADD, 6'd0, 6'd0, ADDEND_MAX);
        push_item(CMD_ADD, 6'd0, 6'd0, ADDEND_MAX);
        push_item(CMD_ADD, 6'd0, 6'd0, ADDEND_MIN);
        push_item(CMD_READ, 6'd0, 6'd0, ADDEND_MAX);
        push_item(CMD_ADD, 6'd63, 6'd63, ADDEND_MIN);
        push_item(CMD_ADD, 6'd63, 6'd63, ADDEND_ONE);
        push_item(CMD_READ_CLR, 6'd63, 6'd63, 32'h1234_5678);
        push_item(CMD_READ, 6'd63, 6'd63, '0);
        push_item(CMD_ALT_READ, 6'd0, 6'd0, ADDEND_MIN);
        push_item(CMD_ADD, 6'd63, 6'd0, '1);
        push_item(CMD_READ_CLR, 6'd63, 6'd0, '0);
        push_item(CMD_ADD, 6'd0, 6'd63, 32'h0000_0001);
        push_item(CMD_READ, 6'd0, 6'd63, '0);

        // single entry: row out of range, column out of range, both, then in range
        reconfigure(1, 1);
        push_item(CMD_ADD, 6'd1, 6'd0, ADDEND_ONE);
        push_item(CMD_ADD, 6'd0, 6'd1, ADDEND_ONE);
        push_item(CMD_READ, 6'd63, 6'd63, '0);
        push_item(CMD_ADD, 6'd0, 6'd0, 32'h0000_0005);

        // zero counts flag everything
        reconfigure(0, 0);
        push_item(CMD_READ, 6'd0, 6'd0, '0);
        push_item(CMD_ADD, 6'd63, 6'd63, ADDEND_MAX);

        // counts above the maximum clip to it
        reconfigure(127, 127);
        push_item(CMD_READ, 6'd63, 6'd63, '0);
        push_item(CMD_READ_CLR, 6'd0, 6'd0, '0);

        reconfigure(64, 64);
        repeat (60) push_random_item();
        reconfigure(1, 64);
        repeat (60) push_random_item();
        reconfigure(64, 1);
        repeat (60) push_random_item();

        // long receiver hold-off while commands keep coming
        reconfigure(7, 9);
        gaps_on = 1'b0;
        repeat (20) push_random_item();
        hold_requests++;
        repeat (60) push_random_item();
        gaps_on = 1'b1;

        reconfigure(0, 5);
        repeat (30) push_random_item();

        // sender pauses mid-stream until every response is back
        reconfigure(127, 127);
        repeat (30) push_random_item();
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) push_random_item();

        reconfigure($urandom_range(1, 64), $urandom_range(1, 64));
        repeat (60) push_random_item();
        reconfigure($urandom_range(0, 127), $urandom_range(0, 127));
        repeat (60) push_random_item();

        // drive one entry into positive then negative saturation
        reconfigure(64, 64);
        repeat (SAT_RUN) push_item(CMD_ADD, 6'd5, 6'd7, ADDEND_MAX);
        push_item(CMD_READ_CLR, 6'd5, 6'd7, '0);
        repeat (SAT_RUN) push_item(CMD_ADD, 6'd5, 6'd7, ADDEND_MIN);
        push_item(CMD_READ, 6'd5, 6'd7, '0);
        push_item(CMD_ADD, 6'd5, 6'd7, ADDEND_MAX);

        // closing stretch at full rate on both sides
        gaps_on = 1'b0;
        reconfigure($urandom_range(1, 64), $urandom_range(1, 64));
        repeat (100) push_random_item();
        cmd_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        $display("covered %0d command transactions, %0d flagged out of range, %0d saturated sums",
                 transactions, flagged, saturated);
        $display("register counts swept from zero through 127, %0d mismatches", errors);
        if (errors == 0) begin
            $display("sparse_triplet_scatter_accumulate_tb: PASS");
        end else begin
            $display("sparse_triplet_scatter_accumulate_tb: FAIL");
        end
        $finish;
    end

endmodule
